FILE: hdl/bpcb_pkg.sv
// Shared types and constants for the button press classifier with LED blink.
// No dependencies; the top level and the checker take it by wildcard import.
package bpcb_pkg;

  localparam int CFG_WIDTH  = 16;
  localparam int ADDR_WIDTH = 2;
  localparam int DATA_BYTES = 1;

  // Configuration register indexes.
  localparam logic [ADDR_WIDTH-1:0] CFG_SHORT_PRESS = 2'd0;
  localparam logic [ADDR_WIDTH-1:0] CFG_LONG_PRESS  = 2'd1;
  localparam logic [ADDR_WIDTH-1:0] CFG_SHORT_BLINK = 2'd2;
  localparam logic [ADDR_WIDTH-1:0] CFG_LONG_HOLD   = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [CFG_WIDTH-1:0] SHORT_PRESS_RST = 16'd50;
  localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RST  = 16'd700;
  localparam logic [CFG_WIDTH-1:0] SHORT_BLINK_RST = 16'd300;
  localparam logic [CFG_WIDTH-1:0] LONG_HOLD_RST   = 16'd1000;

  // Action codes returned on a fetch.
  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_TOGGLE = 2'd1,
    ACT_IGNORE = 2'd2
  } action_t;

  // Two-blink pattern phases.
  typedef enum logic [1:0] {
    BLK_IDLE = 2'd0,
    BLK_ON1  = 2'd1,
    BLK_OFF1 = 2'd2,
    BLK_ON2  = 2'd3
  } blink_phase_t;

endpackage

FILE: hdl/button_press_classifier_with_blink_top.sv
// Top level of the button press classifier with LED blink feedback.
// Depends on bpcb_pkg for register indexes, reset values and enum types.
//
// Usage: the in_ channel carries one transaction per millisecond tick with the
// button level and a fetch request. For every accepted tick exactly one result
// transaction leaves on the out_ channel with the LED level, the ready flag
// and the fetched action. The block times each press, classifies it on
// release as short or long, then plays two blinks (short) or one long hold
// (long) on the LED before it reports ready. A fetch returns the action and
// clears the pending flags.
// The result of an accepted tick is registered in the result or skid register.
// Throughput is one tick per cycle while in_tready is high; all tick work is
// a few subtracts and compares on timestamps between state and result registers.
// A two-entry output buffer (result register plus skid register) lets a tick
// be taken while a result waits; in_tready drops only when both are full.
// Reset (synchronous, active low) clears the time base, press and display
// state, empties the output buffer and loads the default thresholds.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata while idle.
module button_press_classifier_with_blink_top #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [0] button_down, [1] fetch, [7:2] zero
  input  logic [8*bpcb_pkg::DATA_BYTES-1:0] in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [0] led_on, [1] input_ready, [3:2] action, [7:4] zero
  output logic [8*bpcb_pkg::DATA_BYTES-1:0] out_tdata,
  input  logic                           cfg_we,
  input  logic [bpcb_pkg::ADDR_WIDTH-1:0] cfg_addr,
  input  logic [bpcb_pkg::CFG_WIDTH-1:0]  cfg_wdata
);
  import bpcb_pkg::*;

  // Compare width covers both the timestamps and three blink phases.
  localparam int CW = (TIME_WIDTH > CFG_WIDTH + 2) ? TIME_WIDTH : CFG_WIDTH + 2;
  localparam int DW = 8 * DATA_BYTES;

  logic [CFG_WIDTH-1:0] short_press_r, long_press_r, short_blink_r, long_hold_r;

  logic [TIME_WIDTH-1:0] now_r, press_start_r, blink_start_r, hold_start_r;
  logic [TIME_WIDTH-1:0] press_start_nxt, blink_start_nxt, hold_start_nxt;
  logic                  press_active_r, short_pending_r, long_pending_r;
  logic                  display_done_r, hold_active_r, led_r;
  logic                  press_active_nxt, short_pending_nxt, long_pending_nxt;
  logic                  display_done_nxt, hold_active_nxt, led_nxt;
  blink_phase_t          blink_phase_r, blink_phase_nxt;

  logic                  in_fire;
  logic                  btn_down, fetch_req;
  logic                  sp_p, lp_p, dd_p;
  logic [TIME_WIDTH-1:0] press_len, blink_len, hold_len;
  logic [CFG_WIDTH+1:0]  blink_end1, blink_end2, blink_end3;
  logic                  c1, c2, c3, adv1, adv2, adv3, blink_run;
  logic                  ready_nxt;
  action_t               action_nxt;
  logic [DW-1:0]         result;

  logic                  out_valid_r, skid_valid_r;
  logic [DW-1:0]         out_data_r, skid_data_r;

  assign in_tready  = !skid_valid_r;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign btn_down  = in_tdata[0];
  assign fetch_req = in_tdata[1];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_press_r <= SHORT_PRESS_RST;
      long_press_r  <= LONG_PRESS_RST;
      short_blink_r <= SHORT_BLINK_RST;
      long_hold_r   <= LONG_HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SHORT_PRESS: short_press_r <= cfg_wdata;
        CFG_LONG_PRESS:  long_press_r  <= cfg_wdata;
        CFG_SHORT_BLINK: short_blink_r <= cfg_wdata;
        CFG_LONG_HOLD:   long_hold_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Press timing and classification on release.
  always_comb begin
    press_len        = now_r - press_start_r;
    press_start_nxt  = press_start_r;
    press_active_nxt = press_active_r;
    sp_p             = short_pending_r;
    lp_p             = long_pending_r;
    dd_p             = display_done_r;
    if (btn_down) begin
      if (!press_active_r) begin
        press_start_nxt  = now_r;
        press_active_nxt = 1'b1;
        dd_p             = 1'b0;
      end
    end else if (press_active_r) begin
      if (CW'(press_len) > CW'(long_press_r)) begin
        lp_p = 1'b1;
      end else if (CW'(press_len) > CW'(short_press_r)) begin
        sp_p = 1'b1;
      end
      press_active_nxt = 1'b0;
    end
  end

  // Phase boundaries of the blink pattern; several may pass in one tick.
  assign blink_len  = now_r - blink_start_r;
  assign blink_end1 = {2'b00, short_blink_r};
  assign blink_end2 = {1'b0, short_blink_r, 1'b0};
  assign blink_end3 = blink_end1 + blink_end2;
  assign c1 = CW'(blink_len) > CW'(blink_end1);
  assign c2 = CW'(blink_len) > CW'(blink_end2);
  assign c3 = CW'(blink_len) > CW'(blink_end3);
  assign adv1 = (blink_phase_r == BLK_ON1) && c1;
  assign adv2 = ((blink_phase_r == BLK_OFF1) || adv1) && c2;
  assign adv3 = ((blink_phase_r == BLK_ON2) || adv2) && c3;
  assign blink_run = sp_p && !dd_p;

  // Blink phase next state.
  always_comb begin
    blink_phase_nxt = blink_phase_r;
    if (blink_run) begin
      unique case (blink_phase_r) inside
        BLK_IDLE: blink_phase_nxt = BLK_ON1;
        BLK_ON1, BLK_OFF1, BLK_ON2: begin
          if (adv3) begin
            blink_phase_nxt = BLK_IDLE;
          end else if (adv2) begin
            blink_phase_nxt = BLK_ON2;
          end else if (adv1) begin
            blink_phase_nxt = BLK_OFF1;
          end
        end
        default: blink_phase_nxt = BLK_IDLE;
      endcase
    end
  end

  // LED level, long hold, fetch and the result fields.
  always_comb begin
    hold_len          = now_r - hold_start_r;
    led_nxt           = led_r;
    blink_start_nxt   = blink_start_r;
    hold_start_nxt    = hold_start_r;
    hold_active_nxt   = hold_active_r;
    display_done_nxt  = dd_p;
    short_pending_nxt = sp_p;
    long_pending_nxt  = lp_p;
    action_nxt        = ACT_NONE;

    if (blink_run) begin
      if (blink_phase_r == BLK_IDLE) begin
        blink_start_nxt = now_r;
        led_nxt         = 1'b1;
      end else if (adv3) begin
        led_nxt = 1'b0;
      end else if (adv2) begin
        led_nxt = 1'b1;
      end else if (adv1) begin
        led_nxt = 1'b0;
      end
      display_done_nxt = (blink_phase_r != BLK_IDLE) && adv3;
    end

    // The long hold runs only while the display is not marked done.
    if (lp_p && !display_done_nxt) begin
      if (!hold_active_r) begin
        hold_start_nxt  = now_r;
        hold_active_nxt = 1'b1;
        led_nxt         = 1'b1;
      end else if (CW'(hold_len) > CW'(long_hold_r)) begin
        hold_active_nxt  = 1'b0;
        led_nxt          = 1'b0;
        display_done_nxt = 1'b1;
      end
    end

    if (fetch_req) begin
      if (sp_p) begin
        action_nxt = ACT_TOGGLE;
      end else if (lp_p) begin
        action_nxt = ACT_IGNORE;
      end
      short_pending_nxt = 1'b0;
      long_pending_nxt  = 1'b0;
    end

    ready_nxt = (short_pending_nxt || long_pending_nxt) && display_done_nxt;
  end

  assign result = {{(DW-4){1'b0}}, action_nxt, ready_nxt, led_nxt};

  // Tick state advances only on an accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r           <= '0;
      press_start_r   <= '0;
      press_active_r  <= 1'b0;
      short_pending_r <= 1'b0;
      long_pending_r  <= 1'b0;
      display_done_r  <= 1'b0;
      blink_start_r   <= '0;
      blink_phase_r   <= BLK_IDLE;
      hold_start_r    <= '0;
      hold_active_r   <= 1'b0;
      led_r           <= 1'b0;
    end else if (in_fire) begin
      now_r           <= now_r + 1'b1;
      press_start_r   <= press_start_nxt;
      press_active_r  <= press_active_nxt;
      short_pending_r <= short_pending_nxt;
      long_pending_r  <= long_pending_nxt;
      display_done_r  <= display_done_nxt;
      blink_start_r   <= blink_start_nxt;
      blink_phase_r   <= blink_phase_nxt;
      hold_start_r    <= hold_start_nxt;
      hold_active_r   <= hold_active_nxt;
      led_r           <= led_nxt;
    end
  end

  // Output buffer: the result register and a skid register behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (in_fire) begin
      if (!out_valid_r || out_tready) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_valid_r && out_tready) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (!out_valid_r || out_tready) begin
        out_data_r <= result;
      end else begin
        skid_data_r <= result;
      end
    end else if (out_valid_r && out_tready && skid_valid_r) begin
      out_data_r <= skid_data_r;
    end
  end

endmodule

FILE: hdl/bpcb_checker.sv
// Port-level checks for the button press classifier top level, and the bind
// that attaches them. Depends on bpcb_pkg and button_press_classifier_with_blink_top.
module bpcb_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [8*bpcb_pkg::DATA_BYTES-1:0]  out_tdata
);
  import bpcb_pkg::*;

  // The output buffer is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // A fetch clears the flags, so a returned action never comes with ready.
  a_fetch_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[3:2] != ACT_NONE) |-> !out_tdata[1])
    else $error("ready reported together with a fetched action");

  // Only the defined action codes appear.
  a_action_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[3:2] == ACT_NONE || out_tdata[3:2] == ACT_TOGGLE
                    || out_tdata[3:2] == ACT_IGNORE))
    else $error("undefined action code");

  // Once a result is taken the skid stage is free again.
  a_ready_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> in_tready)
    else $error("input stalled after a result was taken");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind button_press_classifier_with_blink_top bpcb_checker u_bpcb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
